// ===== rtl/core/mbps_pkg.sv =====
// ----------------------------------------------------------------------------
// mbps_pkg
// Shared types and constants for the masked bit pattern search block.
// ----------------------------------------------------------------------------
package mbps_pkg;

  localparam int WIN_BITS       = 64;
  localparam int DIGIT_BITS     = 4;
  localparam int CFG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS  = 64;

  // input tdata layout: data_word in [31:0], valid_digits in [35:32]
  localparam int IN_WORD_BITS   = 32;
  localparam int IN_DATA_BITS   = 40;

  localparam logic [CFG_INDEX_BITS-1:0] REG_PATTERN = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_MASK    = 2'd1;

  localparam logic [WIN_BITS-1:0] RESET_PATTERN = 64'h0BD3_E5E8_0000_0000;
  localparam logic [WIN_BITS-1:0] RESET_MASK    = 64'h0FFF_FFF8_0000_0000;

  typedef struct packed {
    logic [WIN_BITS-1:0] pattern;
    logic [WIN_BITS-1:0] mask;
  } mbps_cfg_t;

  typedef struct packed {
    logic                  final_word;
    logic [DIGIT_BITS-1:0] digits;
  } mbps_tail_t;

endpackage

// ===== rtl/core/mbps_lane.sv =====
// ----------------------------------------------------------------------------
// mbps_lane
// One compare lane: tests the window at a fixed bit offset.
// ----------------------------------------------------------------------------
module mbps_lane import mbps_pkg::*; #(
  parameter int OFFSET    = 0,
  parameter int WORD_BITS = 32
) (
  input  logic [WIN_BITS-1:0] window,
  input  mbps_cfg_t           cfg,
  input  mbps_tail_t          tail,
  output logic                hit
);

  localparam int VB = 7;

  logic [WIN_BITS-1:0] shifted;
  logic [VB-1:0]       vbits;
  logic                tail_bad;

  assign shifted = window << OFFSET;

  // valid bits at the top of the window at this offset (final word only)
  assign vbits = VB'(WORD_BITS) + VB'({tail.digits, 2'b00}) - VB'(OFFSET);

  // any mask bit below the valid region kills the match
  assign tail_bad = tail.final_word &&
                    ((cfg.mask & ({WIN_BITS{1'b1}} >> vbits)) != '0);

  assign hit = ((shifted & cfg.mask) == cfg.pattern) && !tail_bad;

endmodule

// ===== rtl/core/mbps_merge.sv =====
// ----------------------------------------------------------------------------
// mbps_merge
// Merges lane hits: emits one position per hit, lowest offset first.
// ----------------------------------------------------------------------------
module mbps_merge import mbps_pkg::*; #(
  parameter int POSITION_BITS = 48,
  parameter int WORD_BITS     = 32
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     load_valid,
  output logic                     load_ready,
  input  logic [WORD_BITS-1:0]     load_hits,
  input  logic [POSITION_BITS-1:0] load_base,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [POSITION_BITS-1:0] out_position,
  output logic                     out_last
);

  localparam int IDX_BITS = (WORD_BITS > 1) ? $clog2(WORD_BITS) : 1;

  logic                     busy;
  logic [WORD_BITS-1:0]     hits;
  logic [POSITION_BITS-1:0] base;

  logic [WORD_BITS-1:0]     lowbit;
  logic [WORD_BITS-1:0]     hits_next;
  logic [IDX_BITS-1:0]      idx;
  logic [POSITION_BITS:0]   sum;
  logic                     pop;

  assign lowbit    = hits & (~hits + WORD_BITS'(1));
  assign hits_next = hits & (hits - WORD_BITS'(1));

  always_comb begin
    idx = '0;
    for (int b = 0; b < WORD_BITS; b++) begin
      if (lowbit[b]) begin
        idx = idx | IDX_BITS'(b);
      end
    end
  end

  // saturating position: base never exceeds max, so carry out means overflow
  assign sum          = {1'b0, base} + (POSITION_BITS + 1)'(idx);
  assign out_position = sum[POSITION_BITS] ? {POSITION_BITS{1'b1}}
                                           : sum[POSITION_BITS-1:0];
  assign out_last     = (hits_next == '0);
  assign out_valid    = busy;

  assign pop        = busy && out_ready;
  assign load_ready = !busy || (out_ready && out_last);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (load_valid && load_ready) begin
      busy <= 1'b1;
    end else if (pop && out_last) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_valid && load_ready) begin
      hits <= load_hits;
      base <= load_base;
    end else if (pop) begin
      hits <= hits_next;
    end
  end

endmodule

// ===== rtl/core/masked_bit_pattern_search.sv =====
// ----------------------------------------------------------------------------
// masked_bit_pattern_search
// Masked 64-bit pattern search over a hex-digit word stream, all word
// offsets compared in parallel lanes, hits merged into a position stream.
// ----------------------------------------------------------------------------
//
//  channel   dir  handshake               payload
//  --------  ---  ----------------------  ------------------------------------
//  s_axis    in   s_axis_tvalid/tready    tdata: data_word, valid_digits
//  m_axis    out  m_axis_tvalid/tready    tdata: match_position, tlast: last
//  cfg       in   cfg_valid/cfg_ready     cfg_index, cfg_data
//
//  Flow: one request accepted per cycle while no hits are pending. A word
//  with k hits (k >= 1) holds the merge stage until all k positions are
//  taken; the lane stage keeps one more word waiting behind it.
//  Pipeline: lanes register on accept, then the merge stage shows the first hit.
//  Reset: rst (sync, high) restores the default pattern and mask, clears the
//  window, stream position and end flag. cfg_ready is always high.
//  Stalls: m_axis_tready low holds the current hit; s_axis_tready drops only
//  when the lane stage holds hits the merge stage cannot yet take.
//
module masked_bit_pattern_search import mbps_pkg::*; #(
  parameter int POSITION_BITS = 48,
  parameter int WORD_BITS     = 32
) (
  input  logic                                clk,
  input  logic                                rst,
  // cfg write channel
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [CFG_INDEX_BITS-1:0]           cfg_index,
  input  logic [CFG_DATA_BITS-1:0]            cfg_data,
  // input stream
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [IN_DATA_BITS-1:0]             s_axis_tdata,  // [31:0] data_word, [35:32] valid_digits
  // result stream
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [((POSITION_BITS+7)/8)*8-1:0]  m_axis_tdata,  // [POSITION_BITS-1:0] match_position
  output logic                                m_axis_tlast   // last_match
);

  localparam int OUT_BITS = ((POSITION_BITS + 7) / 8) * 8;
  localparam logic [DIGIT_BITS-1:0] DIGITS_PER_WORD = DIGIT_BITS'(WORD_BITS / 4);

  // configuration
  mbps_cfg_t cfg;

  // stream state
  logic [WORD_BITS-1:0]     prev_word;
  logic                     primed;
  logic [POSITION_BITS-1:0] bit_position;
  logic                     stream_ended;

  // lane stage register
  logic                     s1_valid;
  logic [WORD_BITS-1:0]     s1_hits;
  logic [POSITION_BITS-1:0] s1_base;

  logic [WORD_BITS-1:0]     word;
  mbps_tail_t               tail;
  logic [WIN_BITS-1:0]      window;
  logic [WORD_BITS-1:0]     hits;
  logic                     accept;
  logic                     merge_ready;
  logic [POSITION_BITS:0]   pos_sum;
  logic [POSITION_BITS-1:0] bit_position_next;
  logic [POSITION_BITS-1:0] out_position;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pattern <= RESET_PATTERN;
      cfg.mask    <= RESET_MASK;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_PATTERN: cfg.pattern <= cfg_data;
        REG_MASK:    cfg.mask    <= cfg_data;
        default:     ;
      endcase
    end
  end

  assign word            = s_axis_tdata[WORD_BITS-1:0];
  assign tail.digits     = s_axis_tdata[IN_WORD_BITS +: DIGIT_BITS];
  assign tail.final_word = tail.digits < DIGITS_PER_WORD;

  // previous word on top, current word below, zeros under both when 2*WORD_BITS < WIN_BITS
  assign window = (WIN_BITS'(prev_word) << (WIN_BITS - WORD_BITS)) |
                  (WIN_BITS'(word) << (WIN_BITS - 2 * WORD_BITS));

  for (genvar g = 0; g < WORD_BITS; g++) begin : g_lane
    mbps_lane #(
      .OFFSET    (g),
      .WORD_BITS (WORD_BITS)
    ) u_lane (
      .window (window),
      .cfg    (cfg),
      .tail   (tail),
      .hit    (hits[g])
    );
  end

  assign s_axis_tready = !s1_valid || merge_ready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  // stream position advances by a word, stops at its max
  assign pos_sum           = {1'b0, bit_position} + (POSITION_BITS + 1)'(WORD_BITS);
  assign bit_position_next = pos_sum[POSITION_BITS] ? {POSITION_BITS{1'b1}}
                                                    : pos_sum[POSITION_BITS-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      primed       <= 1'b0;
      stream_ended <= 1'b0;
      bit_position <= '0;
      prev_word    <= '0;
    end else if (accept && !stream_ended) begin
      prev_word <= word;
      primed    <= 1'b1;
      if (primed) begin
        bit_position <= bit_position_next;
      end
      if (tail.final_word) begin
        stream_ended <= 1'b1;
      end
    end
  end

  // lane stage: only words that carry hits move on
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_axis_tready) begin
      s1_valid <= accept && primed && !stream_ended && (hits != '0);
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready) begin
      s1_hits <= hits;
      s1_base <= bit_position;
    end
  end

  mbps_merge #(
    .POSITION_BITS (POSITION_BITS),
    .WORD_BITS     (WORD_BITS)
  ) u_merge (
    .clk          (clk),
    .rst          (rst),
    .load_valid   (s1_valid),
    .load_ready   (merge_ready),
    .load_hits    (s1_hits),
    .load_base    (s1_base),
    .out_valid    (m_axis_tvalid),
    .out_ready    (m_axis_tready),
    .out_position (out_position),
    .out_last     (m_axis_tlast)
  );

  assign m_axis_tdata = OUT_BITS'(out_position);

endmodule

// ===== rtl/core/mbps_checker.sv =====
// ----------------------------------------------------------------------------
// mbps_checker
// Port-level checks for masked_bit_pattern_search, bound to the top level.
// ----------------------------------------------------------------------------
module mbps_checker import mbps_pkg::*; #(
  parameter int POSITION_BITS = 48
) (
  input logic                                clk,
  input logic                                rst,
  input logic                                cfg_valid,
  input logic                                cfg_ready,
  input logic                                s_axis_tvalid,
  input logic                                s_axis_tready,
  input logic                                m_axis_tvalid,
  input logic                                m_axis_tready,
  input logic [((POSITION_BITS+7)/8)*8-1:0]  m_axis_tdata,
  input logic                                m_axis_tlast
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("stalled result changed");

  // no result right after reset
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("result valid after reset");

  // a non-last hit is followed at once by the next hit of the same word
  a_burst_cont: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tready && !m_axis_tlast |=> m_axis_tvalid)
    else $error("hit burst broken");

  // hits of one word come out in non-decreasing position order
  a_burst_order: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tready && !m_axis_tlast |=>
      m_axis_tdata[POSITION_BITS-1:0] >= $past(m_axis_tdata[POSITION_BITS-1:0]))
    else $error("hit positions out of order");

  // config writes never back-pressure
  a_cfg_ready: assert property (@(posedge clk) disable iff (rst)
    cfg_valid |-> cfg_ready)
    else $error("cfg write stalled");

endmodule

bind masked_bit_pattern_search mbps_checker #(
  .POSITION_BITS (POSITION_BITS)
) u_mbps_checker (
  .clk           (clk),
  .rst           (rst),
  .cfg_valid     (cfg_valid),
  .cfg_ready     (cfg_ready),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);
